// ===== rtl/rrtct_pkg.sv =====
// Shared codes and constants for the round-robin thread context table.
// Holds op, status and thread state codes and the stack frame sizes; no dependencies.
package rrtct_pkg;

    localparam logic [1:0] OP_CREATE    = 2'd0;
    localparam logic [1:0] OP_SWITCH    = 2'd1;
    localparam logic [1:0] OP_SET_STATE = 2'd2;

    localparam logic [1:0] ST_DEAD    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
    localparam logic [1:0] STAT_NO_THREAD = 2'd3;

    localparam logic [63:0] FRAME_BYTES      = 64'd4096;
    localparam logic [63:0] INIT_FRAME_BYTES = 64'd160;

    typedef logic [63:0] t_word;

endpackage

// ===== rtl/round_robin_thread_context_table.sv =====
// Round-robin thread context table: top level with the sequencer and the context memories.
// Depends on rrtct_pkg for op, status and state codes, the frame sizes and the word type.
//
// One request is taken at a time. Create, set-state and the unused op complete in S_EXEC,
// which registers their response. A switch passes from S_EXEC through S_FIX, to fix the
// current entry when a thread is current, then through S_SCAN_RD and S_SCAN_CHK for each
// entry examined by the scan, then through S_FETCH to fetch the chosen context. The scan
// reads one state entry at a time from the registered read port. The state memory needs no
// clearing pass after reset, because only entries below the thread count are ever read.
module round_robin_thread_context_table #(
    parameter int THREAD_SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  rrtct_pkg::t_word     i_stack_value,
    input  rrtct_pkg::t_word     i_space_root,
    input  logic [3:0]           i_target_id,
    input  logic [1:0]           i_target_state,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output rrtct_pkg::t_word     o_resume_stack,
    output rrtct_pkg::t_word     o_new_space_root,
    output rrtct_pkg::t_word     o_privileged_stack_top,
    output logic [3:0]           o_chosen_id
);
    import rrtct_pkg::*;

    localparam int IW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int CW = $clog2(THREAD_SLOTS + 1);
    localparam int XW = IW + 1;
    localparam int TW = (XW > 4) ? XW : 4;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_FIX      = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CHK = 3'd4;
    localparam logic [2:0] S_FETCH    = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_cur_valid, n_cur_valid;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_next, n_next;
    logic [CW-1:0] r_k, n_k;

    logic [1:0]    r_op;
    t_word         r_sv;
    t_word         r_root;
    logic [3:0]    r_tid;
    logic [1:0]    r_tst;

    logic [1:0]    r_mem_state [THREAD_SLOTS];
    t_word         r_mem_saved [THREAD_SLOTS];
    t_word         r_mem_root  [THREAD_SLOTS];
    t_word         r_mem_top   [THREAD_SLOTS];
    logic [1:0]    r_rd_state;
    t_word         r_rd_saved;
    t_word         r_rd_root;
    t_word         r_rd_top;

    logic          r_out_valid;
    logic [1:0]    r_out_status;
    t_word         r_out_rs;
    t_word         r_out_root;
    t_word         r_out_top;
    logic [3:0]    r_out_id;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] w_addr;
    logic          w_state_en;
    logic [1:0]    w_state_data;
    logic          w_saved_en;
    t_word         w_saved_data;
    logic          w_ctx_en;

    logic          emit;
    logic [1:0]    e_status;
    t_word         e_rs;
    t_word         e_root;
    t_word         e_top;
    logic [3:0]    e_id;

    logic          out_free;
    logic          table_full;
    logic          bad_tid;
    logic          found;
    logic          k_last;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x,
                                               input logic [CW-1:0] cnt);
        logic [XW-1:0] inc;
        inc = {1'b0, x} + XW'(1);
        if (inc == XW'(cnt)) begin
            return '0;
        end
        return inc[IW-1:0];
    endfunction

    assign out_free   = !r_out_valid || i_ready;
    assign table_full = (XW'(r_count) == XW'(THREAD_SLOTS));
    assign bad_tid    = (TW'(r_tid) >= TW'(r_count));
    assign found      = (r_rd_state == ST_READY) || (r_rd_state == ST_RUNNING);
    assign k_last     = ((XW'(r_k) + XW'(1)) == XW'(r_count));
    assign o_ready    = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cur_valid  = r_cur_valid;
        n_cur        = r_cur;
        n_next       = r_next;
        n_k          = r_k;
        rd_addr      = r_next;
        w_addr       = r_next;
        w_state_en   = 1'b0;
        w_state_data = ST_READY;
        w_saved_en   = 1'b0;
        w_saved_data = r_sv;
        w_ctx_en     = 1'b0;
        emit         = 1'b0;
        e_status     = STAT_OK;
        e_rs         = '0;
        e_root       = '0;
        e_top        = '0;
        e_id         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_CREATE: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (table_full) begin
                                e_status = STAT_FULL;
                            end else begin
                                w_addr       = IW'(r_count);
                                w_state_en   = 1'b1;
                                w_state_data = ST_READY;
                                w_saved_en   = 1'b1;
                                w_saved_data = r_sv + (FRAME_BYTES - INIT_FRAME_BYTES);
                                w_ctx_en     = 1'b1;
                                e_id         = 4'(r_count);
                                n_count      = r_count + CW'(1);
                            end
                        end
                    end
                    OP_SWITCH: begin
                        if (r_count == '0) begin
                            if (out_free) begin
                                emit     = 1'b1;
                                e_status = STAT_NO_THREAD;
                                e_rs     = r_sv;
                                n_state  = S_IDLE;
                            end
                        end else if (r_cur_valid) begin
                            w_addr     = r_cur;
                            w_saved_en = 1'b1;
                            rd_addr    = r_cur;
                            n_state    = S_FIX;
                        end else begin
                            n_next  = '0;
                            n_k     = '0;
                            n_state = S_SCAN_RD;
                        end
                    end
                    OP_SET_STATE: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (bad_tid) begin
                                e_status = STAT_BAD_INDEX;
                            end else begin
                                w_addr       = IW'(r_tid);
                                w_state_en   = 1'b1;
                                w_state_data = r_tst;
                                e_id         = r_tid;
                            end
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_FIX: begin
                if (r_rd_state == ST_RUNNING) begin
                    w_addr       = r_cur;
                    w_state_en   = 1'b1;
                    w_state_data = ST_READY;
                end
                n_next  = wrap_inc(r_cur, r_count);
                n_k     = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (found) begin
                    w_addr       = r_next;
                    w_state_en   = 1'b1;
                    w_state_data = ST_RUNNING;
                    n_cur        = r_next;
                    n_cur_valid  = 1'b1;
                    n_state      = S_FETCH;
                end else if (k_last) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        e_status = STAT_NO_THREAD;
                        e_rs     = r_sv;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_next  = wrap_inc(r_next, r_count);
                    n_k     = r_k + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_FETCH: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_rs    = r_rd_saved;
                    e_root  = r_rd_root;
                    e_top   = r_rd_top;
                    e_id    = 4'(r_next);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_next      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur_valid <= n_cur_valid;
            r_cur       <= n_cur;
            r_next      <= n_next;
            r_k         <= n_k;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op   <= i_op;
            r_sv   <= i_stack_value;
            r_root <= i_space_root;
            r_tid  <= i_target_id;
            r_tst  <= i_target_state;
        end
        if (emit) begin
            r_out_status <= e_status;
            r_out_rs     <= e_rs;
            r_out_root   <= e_root;
            r_out_top    <= e_top;
            r_out_id     <= e_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_state_en) begin
            r_mem_state[w_addr] <= w_state_data;
        end
        if (w_saved_en) begin
            r_mem_saved[w_addr] <= w_saved_data;
        end
        if (w_ctx_en) begin
            r_mem_root[w_addr] <= r_root;
            r_mem_top[w_addr]  <= r_sv + FRAME_BYTES;
        end
        r_rd_state <= r_mem_state[rd_addr];
        r_rd_saved <= r_mem_saved[rd_addr];
        r_rd_root  <= r_mem_root[rd_addr];
        r_rd_top   <= r_mem_top[rd_addr];
    end

    assign o_valid                = r_out_valid;
    assign o_status               = r_out_status;
    assign o_resume_stack         = r_out_rs;
    assign o_new_space_root       = r_out_root;
    assign o_privileged_stack_top = r_out_top;
    assign o_chosen_id            = r_out_id;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(THREAD_SLOTS))
        else $error("Thread count exceeds the table size.");

    a_cur_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (XW'(r_cur) < XW'(r_count)))
        else $error("Current thread index is not a registered entry.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (r_k < r_count))
        else $error("Scan ran past the registered entries.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) != S_IDLE))
        else $error("Response appeared without a request in progress.");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for round_robin_thread_context_table: directed and random requests
// are driven through the valid/ready ports and every response is checked against an
// in-bench scheduler model. Depends on rrtct_pkg and the RTL of the table.
module tb_top;
    import rrtct_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SLOTS = 16;
    localparam int RANDOM_REQS = 430;
    localparam int TAIL_CYCLES = 80;
    localparam int LONG_HOLD_AT = 120;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] op;
        t_word      stack_value;
        t_word      space_root;
        logic [3:0] target_id;
        logic [1:0] target_state;
        bit         drain_first;
    } request_t;

    typedef struct {
        logic [1:0] status;
        t_word      resume_stack;
        t_word      new_space_root;
        t_word      privileged_stack_top;
        logic [3:0] chosen_id;
    } outcome_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_op = OP_CREATE;
    t_word      i_stack_value = '0;
    t_word      i_space_root = '0;
    logic [3:0] i_target_id = '0;
    logic [1:0] i_target_state = ST_DEAD;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_status;
    t_word      o_resume_stack;
    t_word      o_new_space_root;
    t_word      o_privileged_stack_top;
    logic [3:0] o_chosen_id;

    round_robin_thread_context_table #(
        .THREAD_SLOTS(SLOTS)
    ) dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_op                   (i_op),
        .i_stack_value          (i_stack_value),
        .i_space_root           (i_space_root),
        .i_target_id            (i_target_id),
        .i_target_state         (i_target_state),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_status               (o_status),
        .o_resume_stack         (o_resume_stack),
        .o_new_space_root       (o_new_space_root),
        .o_privileged_stack_top (o_privileged_stack_top),
        .o_chosen_id            (o_chosen_id)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    request_t    request_q[$];
    outcome_t    outcome_q[$];
    request_t    active_req;
    int          total_reqs = 0;
    int          reqs_accepted = 0;
    int          resps_seen = 0;
    int          errors = 0;
    int          tx_gap = 0;
    int          tx_burst = 0;
    int          rx_hold = 0;
    int          rx_burst = 0;

    int unsigned live_threads = 0;
    bit          has_current = 1'b0;
    int unsigned current_slot = 0;
    logic [1:0]  slot_state [SLOTS] = '{default: ST_DEAD};
    t_word       slot_saved_sp [SLOTS];
    t_word       slot_root [SLOTS];
    t_word       slot_top [SLOTS];

    function automatic outcome_t dispatch_outcome(request_t r);
        outcome_t    res;
        int unsigned nxt;
        bit          found;
        res = '{status: STAT_OK, resume_stack: '0, new_space_root: '0,
                privileged_stack_top: '0, chosen_id: '0};
        case (r.op)
            OP_CREATE: begin
                if (live_threads >= SLOTS) begin
                    res.status = STAT_FULL;
                end else begin
                    slot_state[live_threads] = ST_READY;
                    slot_root[live_threads] = r.space_root;
                    slot_top[live_threads] = r.stack_value + FRAME_BYTES;
                    slot_saved_sp[live_threads] = slot_top[live_threads] - INIT_FRAME_BYTES;
                    res.chosen_id = 4'(live_threads);
                    live_threads++;
                end
            end
            OP_SWITCH: begin
                res.status = STAT_NO_THREAD;
                res.resume_stack = r.stack_value;
                if (live_threads != 0) begin
                    if (has_current && current_slot < live_threads) begin
                        slot_saved_sp[current_slot] = r.stack_value;
                        if (slot_state[current_slot] == ST_RUNNING) begin
                            slot_state[current_slot] = ST_READY;
                        end
                    end
                    nxt = has_current ? (current_slot + 1) % live_threads : 0;
                    found = 1'b0;
                    for (int k = 0; k < live_threads; k++) begin
                        if (!found && (slot_state[nxt] == ST_READY ||
                                       slot_state[nxt] == ST_RUNNING)) begin
                            found = 1'b1;
                            has_current = 1'b1;
                            current_slot = nxt;
                            slot_state[nxt] = ST_RUNNING;
                            res = '{status: STAT_OK, resume_stack: slot_saved_sp[nxt],
                                    new_space_root: slot_root[nxt],
                                    privileged_stack_top: slot_top[nxt],
                                    chosen_id: 4'(nxt)};
                        end
                        if (!found) begin
                            nxt = (nxt + 1) % live_threads;
                        end
                    end
                end
            end
            OP_SET_STATE: begin
                if (r.target_id >= live_threads) begin
                    res.status = STAT_BAD_INDEX;
                end else begin
                    slot_state[r.target_id] = r.target_state;
                    res.chosen_id = r.target_id;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'hFFFF_FFFF_FFFF_F000 + t_word'($urandom_range(0, 8191));
            3: return t_word'($urandom_range(0, 4095));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_req(logic [1:0] op, t_word sv, t_word root, logic [3:0] tid,
                           logic [1:0] tst, bit drain = 1'b0);
        request_q.push_back('{op: op, stack_value: sv, space_root: root, target_id: tid,
                              target_state: tst, drain_first: drain});
    endtask

    task automatic check_field(string name, t_word want, t_word got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                outcome_q.push_back(dispatch_outcome(active_req));
                reqs_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].drain_first && outcome_q.size() != 0)) begin
                    active_req = request_q.pop_front();
                    i_valid <= 1'b1;
                    i_op <= active_req.op;
                    i_stack_value <= active_req.stack_value;
                    i_space_root <= active_req.space_root;
                    i_target_id <= active_req.target_id;
                    i_target_state <= active_req.target_state;
                    if (tx_burst > 0) begin
                        tx_burst--;
                    end else begin
                        tx_gap = pick_gap();
                        if ($urandom_range(0, 29) == 0) tx_burst = $urandom_range(20, 60);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        outcome_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: response with no request outstanding, expected none, got status %0d id %0d",
                             $time, o_status, o_chosen_id);
                    errors++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", t_word'(want.status), t_word'(o_status));
                    check_field("resume_stack", want.resume_stack, o_resume_stack);
                    check_field("new_space_root", want.new_space_root, o_new_space_root);
                    check_field("privileged_stack_top", want.privileged_stack_top,
                                o_privileged_stack_top);
                    check_field("chosen_id", t_word'(want.chosen_id), t_word'(o_chosen_id));
                end
                resps_seen++;
                if (resps_seen == LONG_HOLD_AT) rx_hold = LONG_HOLD_CYCLES;
            end
            if (rx_hold == 0 && rx_burst == 0 && $urandom_range(0, 3) == 0) begin
                rx_hold = pick_gap();
                if ($urandom_range(0, 19) == 0) rx_burst = $urandom_range(20, 80);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (rx_burst > 0) rx_burst--;
            end
        end
    end

    initial begin
        request_t r;
        int       sel;
        add_req(OP_SWITCH, '1, '0, 4'd0, ST_DEAD);
        add_req(OP_SET_STATE, '0, '0, 4'd0, ST_READY);
        add_req(OP_UNUSED, '1, '1, 4'd15, ST_BLOCKED);
        add_req(OP_CREATE, 64'hFFFF_FFFF_FFFF_F800, '1, 4'd0, ST_DEAD);
        add_req(OP_CREATE, '0, '0, 4'd0, ST_DEAD);
        add_req(OP_CREATE, 64'hFFFF_FFFF_FFFF_F000, 64'h0000_0001_2345_6000, 4'd0, ST_DEAD);
        add_req(OP_SET_STATE, '0, '0, 4'd3, ST_READY);
        add_req(OP_SET_STATE, '1, '1, 4'd15, ST_BLOCKED);
        add_req(OP_SWITCH, 64'h0000_7FFF_FFFF_E000, '0, 4'd0, ST_DEAD);
        add_req(OP_SWITCH, '1, '0, 4'd0, ST_DEAD);
        add_req(OP_SWITCH, '0, '0, 4'd0, ST_DEAD);
        add_req(OP_SWITCH, 64'h5555_5555_5555_5555, '0, 4'd0, ST_DEAD);
        add_req(OP_SET_STATE, '0, '0, 4'd0, ST_BLOCKED);
        add_req(OP_SET_STATE, '0, '0, 4'd1, ST_BLOCKED);
        add_req(OP_SET_STATE, '0, '0, 4'd2, ST_BLOCKED);
        add_req(OP_SWITCH, 64'hAAAA_AAAA_AAAA_AAAA, '0, 4'd0, ST_DEAD, 1'b1);
        add_req(OP_SET_STATE, '0, '0, 4'd1, ST_RUNNING);
        add_req(OP_SWITCH, 64'h0123_4567_89AB_CDEF, '0, 4'd0, ST_DEAD);
        add_req(OP_SET_STATE, '0, '0, 4'd2, ST_DEAD);
        add_req(OP_SET_STATE, '0, '0, 4'd0, ST_READY);
        add_req(OP_SWITCH, 64'hFEDC_BA98_7654_3210, '0, 4'd0, ST_DEAD);
        add_req(OP_SET_STATE, '0, '0, 4'd1, ST_READY);
        for (int n = 0; n < RANDOM_REQS; n++) begin
            r.stack_value = rand_word();
            r.space_root = rand_word();
            r.target_id = 4'($urandom_range(0, 15));
            r.drain_first = ($urandom_range(0, 49) == 0);
            sel = $urandom_range(0, 99);
            r.target_state = sel < 40 ? ST_READY : sel < 70 ? ST_BLOCKED :
                             sel < 85 ? ST_RUNNING : ST_DEAD;
            sel = $urandom_range(0, 99);
            r.op = sel < 12 ? OP_CREATE : sel < 60 ? OP_SWITCH :
                   sel < 95 ? OP_SET_STATE : OP_UNUSED;
            request_q.push_back(r);
        end
        total_reqs = request_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_accepted != total_reqs) @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rrtct_pkg.sv
rtl/round_robin_thread_context_table.sv
bench/tb_top.sv
